### rtl/tps_pkg.sv
// tone pattern sequencer package: command codes, field widths and reset constants
// no dependencies; used by the channel interfaces and the top level
package tps_pkg;

  // field widths of the request and response words
  localparam int CMD_W      = 3;
  localparam int DUR_W      = 16;
  localparam int FREQ_W     = 16;
  localparam int STEP_IDX_W = 4;
  localparam int PLEN_W     = 5;
  localparam int POS_W      = 4;

  // table slots reachable through the step index field
  localparam int STEP_SLOTS = 2 ** STEP_IDX_W;

  // tone frequency after reset, in hertz
  localparam logic [FREQ_W-1:0] RESET_FREQ = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_BEEP     = 3'd1,
    CMD_TONE_ON  = 3'd2,
    CMD_TONE_OFF = 3'd3,
    CMD_LOAD     = 3'd4,
    CMD_PLAY     = 3'd5
  } cmd_t;

endpackage

### rtl/tps_ifs.sv
// valid/ready channel interfaces for the tone pattern sequencer
// request word carries a command, response word the buzzer status; uses tps_pkg
interface tps_req_if;
  import tps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [DUR_W-1:0]      duration;
  logic [FREQ_W-1:0]     freq_hz;
  logic [STEP_IDX_W-1:0] step_index;
  logic [PLEN_W-1:0]     pattern_length;
  logic                  loop_mode;

  modport source (
    output valid, cmd, duration, freq_hz, step_index, pattern_length, loop_mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, duration, freq_hz, step_index, pattern_length, loop_mode,
    output ready
  );
endinterface

interface tps_rsp_if;
  import tps_pkg::*;

  logic              valid;
  logic              ready;
  logic              tone_active;
  logic [FREQ_W-1:0] tone_freq;
  logic              beep_busy;
  logic              pattern_busy;
  logic [POS_W-1:0]  pattern_position;
  logic              sound_phase;

  modport source (
    output valid, tone_active, tone_freq, beep_busy, pattern_busy,
           pattern_position, sound_phase,
    input  ready
  );
  modport sink (
    input  valid, tone_active, tone_freq, beep_busy, pattern_busy,
           pattern_position, sound_phase,
    output ready
  );
endinterface

### rtl/tone_pattern_sequencer.sv
// tone pattern sequencer top level: beep timer, pattern player and step table
// depends on tps_pkg and the tps_req_if / tps_rsp_if channel interfaces
//
// Buzzer controller driven by request words: millisecond ticks, timed beep,
// continuous tone on/off, loading of pattern steps and pattern play. Each
// request word yields exactly one response word with the buzzer status after
// that command. A request is captured in an input register, the whole state
// update is one pass of logic, and the response lands in an output register:
// one word per clock sustained while the response side is ready, else the
// output register holds its word and the input register stalls. A beep with
// nonzero duration aborts a running pattern; tone on/off abort both. With
// enabled at 0 every word is still answered but the state is held.
// Only the first min(MAX_STEPS, 16) step entries exist; playing a step that
// was never loaded gives an undefined duration. Durations saturate to
// TIME_BITS.
module tone_pattern_sequencer #(
  parameter int MAX_STEPS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  tps_req_if.sink       req,
  tps_rsp_if.source     rsp
);
  import tps_pkg::*;

  localparam int TBL_DEPTH = (MAX_STEPS < STEP_SLOTS) ? MAX_STEPS : STEP_SLOTS;
  localparam int TBL_W     = $clog2(TBL_DEPTH);
  localparam int PTR_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  // configuration register
  logic enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_we) begin
      enabled <= cfg_wdata;
    end
  end

  // input register
  logic                  s1_valid;
  logic [CMD_W-1:0]      s1_cmd;
  logic [DUR_W-1:0]      s1_duration;
  logic [FREQ_W-1:0]     s1_freq;
  logic [STEP_IDX_W-1:0] s1_step_index;
  logic [PLEN_W-1:0]     s1_plen;
  logic                  s1_loop;
  logic                  s1_adv;
  logic                  s1_fire;
  logic                  o_valid;

  assign s1_adv    = !o_valid || rsp.ready;
  assign s1_fire   = s1_valid && s1_adv;
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd        <= req.cmd;
      s1_duration   <= req.duration;
      s1_freq       <= req.freq_hz;
      s1_step_index <= req.step_index;
      s1_plen       <= req.pattern_length;
      s1_loop       <= req.loop_mode;
    end
  end

  // sequencer state
  logic                 tone_out, tone_out_next;
  logic [FREQ_W-1:0]    current_freq, current_freq_next;
  logic                 beep_running, beep_running_next;
  logic [TIME_BITS-1:0] time_left, time_left_next;
  logic                 pattern_running, pattern_running_next;
  logic [CNT_W-1:0]     steps_in_use, steps_in_use_next;
  logic [PTR_W-1:0]     step_pointer, step_pointer_next;
  logic                 repeat_flag, repeat_flag_next;
  logic [FREQ_W-1:0]    pattern_tone, pattern_tone_next;
  logic                 on_phase, on_phase_next;
  logic [TIME_BITS-1:0] step_table [TBL_DEPTH];

  // duration saturated to the timer width
  logic [TIME_BITS+DUR_W-1:0] dur_wide;
  logic [TIME_BITS-1:0]       dur_sat;

  assign dur_wide = (TIME_BITS + DUR_W)'(s1_duration);
  assign dur_sat  = (dur_wide > (TIME_BITS + DUR_W)'({TIME_BITS{1'b1}}))
                  ? {TIME_BITS{1'b1}} : dur_wide[TIME_BITS-1:0];

  // pattern length saturated to the step count
  logic [CNT_W-1:0] plen_sat;

  assign plen_sat = (32'(s1_plen) > MAX_STEPS) ? CNT_W'(MAX_STEPS) : CNT_W'(s1_plen);

  // next step pointer with wrap and end-of-pattern detect
  logic [PTR_W:0]   ptr_inc;
  logic             ptr_wrap;
  logic [PTR_W:0]   ptr_adv;
  logic [PTR_W-1:0] ptr_new;

  always_comb begin
    ptr_inc  = (PTR_W + 1)'(step_pointer) + (PTR_W + 1)'(1);
    ptr_wrap = 32'(ptr_inc) >= 32'(steps_in_use);
    ptr_adv  = ptr_wrap ? '0 : ptr_inc;
    ptr_new  = (32'(ptr_adv) >= MAX_STEPS) ? '0 : ptr_adv[PTR_W-1:0];
  end

  // state update for one command
  always_comb begin
    tone_out_next        = tone_out;
    current_freq_next    = current_freq;
    beep_running_next    = beep_running;
    time_left_next       = time_left;
    pattern_running_next = pattern_running;
    steps_in_use_next    = steps_in_use;
    step_pointer_next    = step_pointer;
    repeat_flag_next     = repeat_flag;
    pattern_tone_next    = pattern_tone;
    on_phase_next        = on_phase;
    if (s1_fire && enabled) begin
      unique case (cmd_t'(s1_cmd))
        CMD_TICK: begin
          if (beep_running) begin
            if (time_left <= TIME_BITS'(1)) begin
              tone_out_next     = 1'b0;
              beep_running_next = 1'b0;
              time_left_next    = '0;
            end else begin
              time_left_next = time_left - TIME_BITS'(1);
            end
          end else if (pattern_running) begin
            if (time_left > TIME_BITS'(1)) begin
              time_left_next = time_left - TIME_BITS'(1);
            end else if (ptr_wrap && !repeat_flag) begin
              // last step done, no loop: stop and go silent
              pattern_running_next = 1'b0;
              steps_in_use_next    = '0;
              step_pointer_next    = '0;
              on_phase_next        = 1'b1;
              tone_out_next        = 1'b0;
            end else begin
              step_pointer_next = ptr_new;
              on_phase_next     = !ptr_new[0];
              tone_out_next     = !ptr_new[0];
              if (!ptr_new[0]) begin
                current_freq_next = pattern_tone;
              end
              time_left_next = step_table[ptr_new[TBL_W-1:0]];
            end
          end
        end
        CMD_BEEP: begin
          if (dur_sat != '0) begin
            pattern_running_next = 1'b0;
            steps_in_use_next    = '0;
            step_pointer_next    = '0;
            tone_out_next        = 1'b1;
            current_freq_next    = s1_freq;
            time_left_next       = dur_sat;
            beep_running_next    = 1'b1;
          end
        end
        CMD_TONE_ON, CMD_TONE_OFF: begin
          beep_running_next    = 1'b0;
          time_left_next       = '0;
          pattern_running_next = 1'b0;
          steps_in_use_next    = '0;
          step_pointer_next    = '0;
          tone_out_next        = (cmd_t'(s1_cmd) == CMD_TONE_ON);
          if (cmd_t'(s1_cmd) == CMD_TONE_ON) begin
            current_freq_next = s1_freq;
          end
        end
        CMD_PLAY: begin
          if (s1_plen != '0) begin
            beep_running_next    = 1'b0;
            pattern_running_next = 1'b1;
            steps_in_use_next    = plen_sat;
            step_pointer_next    = '0;
            repeat_flag_next     = s1_loop;
            pattern_tone_next    = s1_freq;
            on_phase_next        = 1'b1;
            time_left_next       = step_table[0];
            if (step_table[0] != '0) begin
              tone_out_next     = 1'b1;
              current_freq_next = s1_freq;
            end
          end
        end
        default: begin
          // load step is handled by the table write; unknown codes do nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_out        <= 1'b0;
      current_freq    <= RESET_FREQ;
      beep_running    <= 1'b0;
      time_left       <= '0;
      pattern_running <= 1'b0;
      steps_in_use    <= '0;
      step_pointer    <= '0;
      repeat_flag     <= 1'b0;
      pattern_tone    <= RESET_FREQ;
      on_phase        <= 1'b1;
    end else begin
      tone_out        <= tone_out_next;
      current_freq    <= current_freq_next;
      beep_running    <= beep_running_next;
      time_left       <= time_left_next;
      pattern_running <= pattern_running_next;
      steps_in_use    <= steps_in_use_next;
      step_pointer    <= step_pointer_next;
      repeat_flag     <= repeat_flag_next;
      pattern_tone    <= pattern_tone_next;
      on_phase        <= on_phase_next;
    end
  end

  // step table write
  always_ff @(posedge clk) begin
    if (s1_fire && enabled && cmd_t'(s1_cmd) == CMD_LOAD
        && 32'(s1_step_index) < TBL_DEPTH) begin
      step_table[s1_step_index[TBL_W-1:0]] <= dur_sat;
    end
  end

  // response register
  logic              o_tone;
  logic [FREQ_W-1:0] o_freq;
  logic              o_beep;
  logic              o_pattern;
  logic [POS_W-1:0]  o_pos;
  logic              o_phase;
  logic [PTR_W+POS_W-1:0] ptr_ext;

  assign ptr_ext = (PTR_W + POS_W)'(step_pointer_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_tone    <= tone_out_next;
      o_freq    <= tone_out_next ? current_freq_next : '0;
      o_beep    <= beep_running_next;
      o_pattern <= pattern_running_next;
      o_pos     <= ptr_ext[POS_W-1:0];
      o_phase   <= on_phase_next;
    end
  end

  assign rsp.valid            = o_valid;
  assign rsp.tone_active      = o_tone;
  assign rsp.tone_freq        = o_freq;
  assign rsp.beep_busy        = o_beep;
  assign rsp.pattern_busy     = o_pattern;
  assign rsp.pattern_position = o_pos;
  assign rsp.sound_phase      = o_phase;

  // beep and pattern exclude each other
  a_beep_xor_pattern: assert property (@(posedge clk) disable iff (rst)
    !(beep_running && pattern_running))
    else $error("beep and pattern running together");

  // a running beep always drives the tone
  a_beep_sounds: assert property (@(posedge clk) disable iff (rst)
    beep_running |-> tone_out)
    else $error("beep running with tone off");

  // a playing pattern keeps its pointer inside the step count
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    pattern_running |-> (steps_in_use != '0 && 32'(step_pointer) < 32'(steps_in_use)))
    else $error("pattern pointer outside step count");

  // a word taken while disabled leaves the state untouched
  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !enabled && !cfg_we) |=> ($stable(time_left) && $stable(tone_out)
      && $stable(step_pointer) && $stable(beep_running) && $stable(pattern_running)))
    else $error("state changed while disabled");

endmodule
